// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define LPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line stepper check failed");

// Next-cycle implication, off while reset is held
`define LPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line stepper check failed");

// Next-cycle implication that also holds across reset
`define LPS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line stepper check failed");

`endif

// File: rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and codes for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int unsigned OFFSET_W   = 28;
  localparam int unsigned BPP_W      = 6;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [BPP_W-1:0]    BPP_RESET    = 6'd32;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4096;

  // Item kinds carried on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BPP    = 1'b0,
    REG_STRIDE = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/line_pixel_stepper_core.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper_core
// All-octant Bresenham line rasteriser with frame buffer byte offset.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_tready is high, loads and steps alike, with no gaps.
// A load item (in_tuser = 0) latches a line; each step item (in_tuser = 1)
// returns the current pixel, its byte offset floor(x*bpp/8) + y*stride and
// a last flag through the registered output stage, then moves along the line. Steps
// with no active line, and all loads, return nothing. The Bresenham state
// (error term and coordinates) updates in the cycle an item is taken, so the
// error compare-and-add sets the one-item-per-clock figure. Results sit in an
// output register backed by a skid register; in_tready drops only when both
// hold a result that has not been taken.
// ----------------------------------------------------------------------------
module line_pixel_stepper_core #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W =
    ((2 * COORD_BITS + lps_pkg::OFFSET_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [lps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DATA_W-1:0]            in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                            in_tuser,   // mode
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DATA_W-1:0]           out_tdata,  // pix_x, pix_y, byte_offset
  output logic                            out_tlast   // last
);
  import lps_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned EW    = CW + 1;
  localparam int unsigned WW    = CW + 3;
  localparam int unsigned XP_W  = CW + BPP_W;
  localparam int unsigned YP_W  = CW + STRIDE_W;
  localparam int unsigned SUM_W = ((YP_W > OFFSET_W) ? YP_W : OFFSET_W) + 1;
  localparam logic [CW-1:0] C_ONE = CW'(1);

  typedef struct packed {
    logic                last;
    logic [OFFSET_W-1:0] off;
    logic [CW-1:0]       y;
    logic [CW-1:0]       x;
  } res_t;

  // Configuration registers
  logic [BPP_W-1:0]    bpp_r;
  logic [STRIDE_W-1:0] stride_r;

  // Line state
  logic [CW-1:0]        cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic [CW-1:0]        delta_x_r, delta_y_r;
  logic                 dir_x_neg_r, dir_y_neg_r;
  logic signed [EW-1:0] error_term_r;
  logic                 active_r;

  logic [CW-1:0]        cur_x_nxt, cur_y_nxt, target_x_nxt, target_y_nxt;
  logic [CW-1:0]        delta_x_nxt, delta_y_nxt;
  logic                 dir_x_neg_nxt, dir_y_neg_nxt;
  logic signed [EW-1:0] error_term_nxt;
  logic                 active_nxt;

  // Output stage
  res_t main_r, main_nxt, skid_r, skid_nxt, res_new;
  logic main_valid_r, main_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic in_fire, push, main_free;

  // Load fields
  logic [CW-1:0]        sx, sy, ex, ey, dx_ld, dy_ld;
  logic signed [EW-1:0] half_dx, half_dy, err_ld;

  // Step datapath
  logic signed [WW-1:0] err_w, dx_w, dy_w, err_step;
  logic                 step_x, step_y, last_v;
  logic [CW-1:0]        x_adv, y_adv;
  logic [XP_W-1:0]      xprod;
  logic [YP_W-1:0]      yprod;
  logic [SUM_W-1:0]     off_sum;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign push      = in_fire && (in_tuser == MODE_STEP) && active_r;
  assign main_free = !main_valid_r || out_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RESET;
      stride_r <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BPP:    bpp_r    <= cfg_wdata[BPP_W-1:0];
        REG_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Unpack load coordinates and derive deltas and starting error
  assign sx = in_tdata[CW-1:0];
  assign sy = in_tdata[2*CW-1:CW];
  assign ex = in_tdata[3*CW-1:2*CW];
  assign ey = in_tdata[4*CW-1:3*CW];

  assign dx_ld   = (sx > ex) ? (sx - ex) : (ex - sx);
  assign dy_ld   = (sy > ey) ? (sy - ey) : (ey - sy);
  assign half_dx = $signed({2'b00, dx_ld[CW-1:1]});
  assign half_dy = $signed({2'b00, dy_ld[CW-1:1]});
  assign err_ld  = (dx_ld > dy_ld) ? half_dx : -half_dy;

  // Bresenham step: decide the axes to move and the new error
  assign err_w  = WW'(error_term_r);
  assign dx_w   = $signed({3'b000, delta_x_r});
  assign dy_w   = $signed({3'b000, delta_y_r});
  assign step_x = err_w > -dx_w;
  assign step_y = err_w < dy_w;

  always_comb begin
    err_step = err_w;
    if (step_x) begin
      err_step = err_step - dy_w;
    end
    if (step_y) begin
      err_step = err_step + dx_w;
    end
  end

  assign x_adv  = step_x ? (dir_x_neg_r ? cur_x_r - C_ONE : cur_x_r + C_ONE) : cur_x_r;
  assign y_adv  = step_y ? (dir_y_neg_r ? cur_y_r - C_ONE : cur_y_r + C_ONE) : cur_y_r;
  assign last_v = (x_adv == target_x_r) && (y_adv == target_y_r);

  // Next line state
  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    target_x_nxt   = target_x_r;
    target_y_nxt   = target_y_r;
    delta_x_nxt    = delta_x_r;
    delta_y_nxt    = delta_y_r;
    dir_x_neg_nxt  = dir_x_neg_r;
    dir_y_neg_nxt  = dir_y_neg_r;
    error_term_nxt = error_term_r;
    active_nxt     = active_r;
    if (in_fire) begin
      priority if (in_tuser == MODE_LOAD) begin
        cur_x_nxt      = sx;
        cur_y_nxt      = sy;
        target_x_nxt   = ex;
        target_y_nxt   = ey;
        delta_x_nxt    = dx_ld;
        delta_y_nxt    = dy_ld;
        dir_x_neg_nxt  = !(sx < ex);
        dir_y_neg_nxt  = !(sy < ey);
        error_term_nxt = err_ld;
        active_nxt     = (sx != ex) || (sy != ey);
      end else if (active_r) begin
        cur_x_nxt      = x_adv;
        cur_y_nxt      = y_adv;
        error_term_nxt = err_step[EW-1:0];
        active_nxt     = !last_v;
      end else begin
        // idle step: nothing changes
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    target_x_r   <= target_x_nxt;
    target_y_r   <= target_y_nxt;
    delta_x_r    <= delta_x_nxt;
    delta_y_r    <= delta_y_nxt;
    dir_x_neg_r  <= dir_x_neg_nxt;
    dir_y_neg_r  <= dir_y_neg_nxt;
    error_term_r <= error_term_nxt;
  end

  // Byte offset of the current pixel
  assign xprod   = XP_W'(cur_x_r) * XP_W'(bpp_r);
  assign yprod   = YP_W'(cur_y_r) * YP_W'(stride_r);
  assign off_sum = SUM_W'(xprod >> 3) + SUM_W'(yprod);

  assign res_new.x    = cur_x_r;
  assign res_new.y    = cur_y_r;
  assign res_new.off  = off_sum[OFFSET_W-1:0];
  assign res_new.last = last_v;

  // Output register with skid: drain skid first, park a new item if stalled
  always_comb begin
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = res_new;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = res_new;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = OUT_DATA_W'({main_r.off, main_r.y, main_r.x});
  assign out_tlast  = main_r.last;

endmodule

// File: rtl/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks on the line pixel stepper output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lps_checker #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF,
  localparam int unsigned OUT_DATA_W =
    ((2 * COORD_BITS + lps_pkg::OFFSET_W + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // Reset empties the output stage
  `LPS_ASSERT_ALWAYS(a_rst_empty, !rst_n, !out_tvalid)

  // A stalled item holds its value
  `LPS_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Back-pressure on the input only while a result is waiting
  `LPS_ASSERT_NOW(a_ready_low, !in_tready, out_tvalid)

  // Input stalls only after the output was stalled
  `LPS_ASSERT_NOW(a_ready_fall, $fell(in_tready), $past(out_tvalid && !out_tready))

endmodule

bind line_pixel_stepper_core lps_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (.*);
